[rtl/core/acc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// acc_pkg
// shared types, label codes and the residue property table
// ----------------------------------------------------------------------------
package acc_pkg;

  localparam int RES_W   = 8;
  localparam int LABEL_W = 6;
  localparam int CFG_W   = 4;
  localparam int NPROP   = 10;
  localparam int SUM_W   = CFG_W + 1;

  localparam int DEF_MAX_STRUCTURES = 8;

  localparam logic [CFG_W-1:0] RST_NUM_STRUCT = CFG_W'(2);
  localparam logic [CFG_W-1:0] RST_IGNORE     = CFG_W'(0);

  localparam logic [RES_W-1:0] LETTER_A    = 8'h41;
  localparam logic [RES_W-1:0] LETTER_SPAN = 8'd26;

  localparam logic [LABEL_W-1:0] LBL_UNK     = 6'd23;
  localparam logic [LABEL_W-1:0] LBL_SMALL   = 6'd26;
  localparam logic [LABEL_W-1:0] LBL_TINY    = 6'd27;
  localparam logic [LABEL_W-1:0] LBL_POLAR   = 6'd28;
  localparam logic [LABEL_W-1:0] LBL_HYDRO   = 6'd29;
  localparam logic [LABEL_W-1:0] LBL_POS     = 6'd30;
  localparam logic [LABEL_W-1:0] LBL_NEG     = 6'd31;
  localparam logic [LABEL_W-1:0] LBL_CHARGED = 6'd32;
  localparam logic [LABEL_W-1:0] LBL_AROM    = 6'd33;
  localparam logic [LABEL_W-1:0] LBL_ALIPH   = 6'd34;
  localparam logic [LABEL_W-1:0] LBL_BRANCH  = 6'd35;

  // property bits, listed in priority order
  localparam int P_POS = 0;
  localparam int P_NEG = 1;
  localparam int P_CHA = 2;
  localparam int P_POL = 3;
  localparam int P_ARO = 4;
  localparam int P_TIN = 5;
  localparam int P_BRA = 6;
  localparam int P_SMA = 7;
  localparam int P_ALI = 8;
  localparam int P_HYD = 9;

  localparam logic [LABEL_W-1:0] PROP_LABEL [NPROP] = '{
    LBL_POS, LBL_NEG, LBL_CHARGED, LBL_POLAR, LBL_AROM,
    LBL_TINY, LBL_BRANCH, LBL_SMALL, LBL_ALIPH, LBL_HYDRO
  };

  typedef enum logic [1:0] {
    REG_NUM_STRUCT = 2'd0,
    REG_IGNORE     = 2'd1,
    REG_MARK_IDENT = 2'd2,
    REG_MARK_CONS  = 2'd3
  } cfg_reg_t;

  typedef logic [NPROP-1:0] prop_mask_t;

  typedef struct packed {
    logic [CFG_W-1:0] num_struct;
    logic [CFG_W-1:0] ignore_cnt;
    logic             mark_ident;
    logic             mark_cons;
  } cfg_t;

  typedef struct packed {
    prop_mask_t props;
    logic       same;
  } lane_t;

  function automatic prop_mask_t props_of(input logic [RES_W-1:0] ch);
    prop_mask_t m;
    m = '0;
    case (ch)
      "R", "K": begin
        m[P_POS] = 1'b1; m[P_CHA] = 1'b1; m[P_POL] = 1'b1;
      end
      "H": begin
        m[P_POS] = 1'b1; m[P_CHA] = 1'b1; m[P_POL] = 1'b1; m[P_ARO] = 1'b1;
      end
      "E", "D": begin
        m[P_NEG] = 1'b1; m[P_CHA] = 1'b1; m[P_POL] = 1'b1;
      end
      "Q", "N": begin
        m[P_POL] = 1'b1;
      end
      "T": begin
        m[P_SMA] = 1'b1; m[P_BRA] = 1'b1; m[P_POL] = 1'b1;
      end
      "S", "P", "G": begin
        m[P_SMA] = 1'b1; m[P_TIN] = 1'b1; m[P_POL] = 1'b1;
      end
      "A": begin
        m[P_SMA] = 1'b1; m[P_TIN] = 1'b1; m[P_ALI] = 1'b1;
      end
      "V": begin
        m[P_SMA] = 1'b1; m[P_ALI] = 1'b1; m[P_BRA] = 1'b1; m[P_HYD] = 1'b1;
      end
      "I": begin
        m[P_ALI] = 1'b1; m[P_BRA] = 1'b1; m[P_HYD] = 1'b1;
      end
      "L", "M": begin
        m[P_ALI] = 1'b1; m[P_HYD] = 1'b1;
      end
      "C": begin
        m[P_SMA] = 1'b1; m[P_TIN] = 1'b1; m[P_HYD] = 1'b1;
      end
      "F", "W": begin
        m[P_HYD] = 1'b1; m[P_ARO] = 1'b1;
      end
      "Y": begin
        m[P_HYD] = 1'b1; m[P_ARO] = 1'b1; m[P_POL] = 1'b1;
      end
      default: begin
        m = '0;
      end
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

[rtl/core/alignment_column_conservation.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// alignment_column_conservation
// labels one alignment column per item by identity or property conservation
// ----------------------------------------------------------------------------
// usage:
//   in_*  : one column per item, in_tdata carries residue_0 in the low byte
//           up to residue_7 in the high byte (ascii letters, space for gap)
//   out_* : one result per item, label_index and the all-identical flag
//   cfg_* : register writes (0 structure count, 1 ignore count,
//           2 mark identical, 3 mark conserved), taken at any edge with
//           cfg_wr_en high, meant to change only while the block is idle
//   stages: one lane register stage and one output register stage
//   throughput: one item per cycle while out_tready is high; each structure
//           has its own lane and the merge counts all ten properties at once
//   reset: rst_n low clears both stages and loads the register defaults
//           (count 2, ignore 0, marking off)
//   stall: with out_tready low the output holds, the lane stage still takes
//           one more item, then in_tready drops until the output moves
// ----------------------------------------------------------------------------
module alignment_column_conservation #(
  parameter int MAX_STRUCTURES = acc_pkg::DEF_MAX_STRUCTURES
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // residue_0 .. residue_{MAX_STRUCTURES-1}, eight bits each from bit 0 up
  input  logic [MAX_STRUCTURES*acc_pkg::RES_W-1:0] in_tdata,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // label_index [5:0], all_identical [6], zero [7]
  output logic [7:0]                            out_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  input  logic                                  cfg_wr_en,
  input  logic [1:0]                            cfg_addr,
  input  logic [acc_pkg::CFG_W-1:0]             cfg_wdata
);
  import acc_pkg::*;

  localparam int CntW = $clog2(MAX_STRUCTURES + 1);

  cfg_t            cfg_r;
  logic [CntW-1:0] n_eff;
  logic [MAX_STRUCTURES-1:0] active;
  lane_t           lane_w     [MAX_STRUCTURES];
  lane_t           s1_lane_r  [MAX_STRUCTURES];
  logic [RES_W-1:0] s1_res0_r;
  logic            s1_valid_r;
  logic            s1_valid_nxt;
  logic            s1_ready;
  logic            out_valid_r;
  logic            out_valid_nxt;
  logic [LABEL_W-1:0] out_label_r;
  logic            out_ident_r;
  logic [LABEL_W-1:0] mrg_label;
  logic            mrg_same;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.num_struct <= RST_NUM_STRUCT;
      cfg_r.ignore_cnt <= RST_IGNORE;
      cfg_r.mark_ident <= 1'b0;
      cfg_r.mark_cons  <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_addr))
        REG_NUM_STRUCT: cfg_r.num_struct <= cfg_wdata;
        REG_IGNORE:     cfg_r.ignore_cnt <= cfg_wdata;
        REG_MARK_IDENT: cfg_r.mark_ident <= cfg_wdata[0];
        REG_MARK_CONS:  cfg_r.mark_cons  <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // effective active count, clamped to 1..MAX_STRUCTURES
  always_comb begin
    if (cfg_r.num_struct == '0) begin
      n_eff = CntW'(1);
    end else if (cfg_r.num_struct > CFG_W'(MAX_STRUCTURES)) begin
      n_eff = CntW'(MAX_STRUCTURES);
    end else begin
      n_eff = cfg_r.num_struct[CntW-1:0];
    end
    for (int i = 0; i < MAX_STRUCTURES; i++) begin
      active[i] = CntW'(i) < n_eff;
    end
  end

  for (genvar g = 0; g < MAX_STRUCTURES; g++) begin : g_lane
    acc_lane u_lane (
      .res       (in_tdata[g*RES_W +: RES_W]),
      .res_first (in_tdata[RES_W-1:0]),
      .active    (active[g]),
      .lane      (lane_w[g])
    );
  end

  // handshake
  always_comb begin
    s1_ready      = !out_valid_r || out_tready;
    in_tready     = !s1_valid_r || s1_ready;
    s1_valid_nxt  = in_tready ? in_tvalid : s1_valid_r;
    out_valid_nxt = s1_ready ? s1_valid_r : out_valid_r;
  end

  // lane stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_lane_r <= lane_w;
      s1_res0_r <= in_tdata[RES_W-1:0];
    end
  end

  acc_merge #(
    .NumLanes (MAX_STRUCTURES)
  ) u_merge (
    .lanes     (s1_lane_r),
    .res_first (s1_res0_r),
    .n_active  (n_eff),
    .cfg       (cfg_r),
    .label     (mrg_label),
    .all_same  (mrg_same)
  );

  // output stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s1_valid_r) begin
      out_label_r <= mrg_label;
      out_ident_r <= mrg_same;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_ident_r, out_label_r};

`ifndef SYNTHESIS
  a_label_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[5:0] <= LBL_BRANCH))
    else $error("label out of range");

  a_mixed_no_letter: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[6]) |-> (out_tdata[5:0] >= LBL_UNK))
    else $error("letter label on a mixed column");

  a_lane_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_ready) |=> (s1_valid_r && $stable(s1_res0_r)))
    else $error("lane stage lost an item under stall");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && !s1_valid_r))
    else $error("pipeline not empty after reset");
`endif

endmodule
`default_nettype wire

[rtl/core/acc_lane.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// acc_lane
// one structure lane: property lookup and compare against the first residue
// ----------------------------------------------------------------------------
module acc_lane (
  input  logic [acc_pkg::RES_W-1:0] res,
  input  logic [acc_pkg::RES_W-1:0] res_first,
  input  logic                      active,
  output acc_pkg::lane_t            lane
);
  import acc_pkg::*;

  always_comb begin
    lane.props = active ? props_of(res) : '0;
    lane.same  = !active || (res == res_first);
  end

endmodule
`default_nettype wire

[rtl/core/acc_merge.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// acc_merge
// combines lane results: identity check, property counts and label priority
// ----------------------------------------------------------------------------
module acc_merge #(
  parameter int NumLanes = acc_pkg::DEF_MAX_STRUCTURES
) (
  input  acc_pkg::lane_t                    lanes [NumLanes],
  input  logic [acc_pkg::RES_W-1:0]         res_first,
  input  logic [$clog2(NumLanes+1)-1:0]     n_active,
  input  acc_pkg::cfg_t                     cfg,
  output logic [acc_pkg::LABEL_W-1:0]       label,
  output logic                              all_same
);
  import acc_pkg::*;

  localparam int CntW = $clog2(NumLanes + 1);

  logic [CntW-1:0]    cnt [NPROP];
  logic [NPROP-1:0]   hit;
  logic [RES_W-1:0]   diff;
  logic               letter_ok;
  logic [LABEL_W-1:0] id_label;
  logic [LABEL_W-1:0] prop_label;
  logic               prop_found;

  always_comb begin
    all_same = 1'b1;
    for (int i = 0; i < NumLanes; i++) begin
      all_same = all_same & lanes[i].same;
    end
  end

  always_comb begin
    for (int p = 0; p < NPROP; p++) begin
      cnt[p] = '0;
      for (int i = 0; i < NumLanes; i++) begin
        cnt[p] = cnt[p] + CntW'(lanes[i].props[p]);
      end
      hit[p] = (SUM_W'(cnt[p]) + SUM_W'(cfg.ignore_cnt)) >= SUM_W'(n_active);
    end
  end

  // lowest set bit wins
  always_comb begin
    prop_label = LBL_UNK;
    prop_found = 1'b0;
    for (int p = NPROP - 1; p >= 0; p--) begin
      if (hit[p]) begin
        prop_label = PROP_LABEL[p];
        prop_found = 1'b1;
      end
    end
  end

  always_comb begin
    diff      = res_first - LETTER_A;
    letter_ok = (res_first >= LETTER_A) && (diff <= LETTER_SPAN);
    id_label  = LBL_UNK;
    if ((cfg.mark_cons || cfg.mark_ident) && all_same && letter_ok) begin
      id_label = diff[LABEL_W-1:0];
    end
    label = id_label;
    if (cfg.mark_cons && (id_label == LBL_UNK) && prop_found) begin
      label = prop_label;
    end
  end

endmodule
`default_nettype wire
